FILE: hdl/box_filter_image_downscaler_top_assert.svh
// assertion macros for the box filter downscaler
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_TOP_ASSERT_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_TOP_ASSERT_SVH

// condition must hold in the same cycle
`define BFD_ASSERT_NOW(label, clk, rst_n, cond, check) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
		else $error("bfd assertion failed");

// condition must hold in the cycle after
`define BFD_ASSERT_NEXT(label, clk, rst_n, cond, check) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
		else $error("bfd assertion failed");

`endif

FILE: hdl/bfd_pkg.sv
// shared types, constants and helpers of the box filter downscaler
package bfd_pkg;

	localparam int DEF_MAX_WIDTH    = 4096;
	localparam int DEF_MAX_HEIGHT   = 4096;
	localparam int DEF_MAX_CHANNELS = 4;
	localparam int SIZE_W           = 13;
	localparam int DIV_W            = 2 * SIZE_W;
	localparam int SUM_W            = 32;
	localparam int SPAN_W           = 20;

	localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [2:0] REG_MODE       = 3'd4;

	localparam logic [1:0] MODE_GRAY = 2'd0;
	localparam logic [1:0] MODE_RGB  = 2'd1;

	typedef enum logic [2:0] {
		ST_START,
		ST_INIT,
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} bfd_state_t;

	typedef struct packed {
		logic             acc;
		logic             clr;
		logic             sum;
		logic             first_row;
		logic             step;
		logic [2:0]       bit_idx;
		logic [DIV_W-1:0] div;
	} lane_ctl_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W:0] maxv);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) r = SIZE_W'(1);
		else if ({1'b0, v} > maxv) r = maxv[SIZE_W-1:0];
		return r;
	endfunction

endpackage

FILE: hdl/box_filter_image_downscaler_top.sv
// top level of the box filter downscaler: control, config port, lanes, merge
// a pixel that does not close a column span is taken while the sequencer stays in ST_IDLE
// a pixel that closes a span reads the line store, then ST_SUM writes the sum back
// on the last row of a row span, ST_DIV runs 8 divider steps and ST_OUT waits for the merge stage
// after reset or a register write, s_tready stays low until both span ratio units are done
// reset clears counters, span sums and output valid; the line store is not cleared
`include "box_filter_image_downscaler_top_assert.svh"
module box_filter_image_downscaler_top
	import bfd_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // in_c0, in_c1, in_c2, in_c3
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_c0, out_c1, out_c2, out_c3
	output logic        m_tlast,   // end_of_row
	output logic        m_tuser,   // end_of_frame
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [SIZE_W:0] MAXW = (SIZE_W+1)'(MAX_WIDTH);
	localparam logic [SIZE_W:0] MAXH = (SIZE_W+1)'(MAX_HEIGHT);

	// configuration registers
	logic [SIZE_W-1:0] sw_q, sh_q, dw_q, dh_q;
	logic [1:0]        mode_q;
	logic              cfg_wr;
	logic [2:0]        reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= SIZE_W'(1);
			sh_q   <= SIZE_W'(1);
			dw_q   <= SIZE_W'(1);
			dh_q   <= SIZE_W'(1);
			mode_q <= MODE_RGB;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SRC_WIDTH:  sw_q   <= pwdata[SIZE_W-1:0];
				REG_SRC_HEIGHT: sh_q   <= pwdata[SIZE_W-1:0];
				REG_DST_WIDTH:  dw_q   <= pwdata[SIZE_W-1:0];
				REG_DST_HEIGHT: dh_q   <= pwdata[SIZE_W-1:0];
				REG_MODE:       mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SRC_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, sw_q};
			REG_SRC_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, sh_q};
			REG_DST_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, dw_q};
			REG_DST_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, dh_q};
			REG_MODE:       prdata = {30'd0, mode_q};
			default:        prdata = '0;
		endcase
	end

	// effective sizes after clamping
	logic [SIZE_W-1:0] sw_e, sh_e, dw_e, dh_e, dw_c, dh_c;
	logic [2:0]        nch;
	logic [3:0]        lane_en;

	assign sw_e = clamp_size(sw_q, MAXW);
	assign sh_e = clamp_size(sh_q, MAXH);
	assign dw_c = clamp_size(dw_q, MAXW);
	assign dh_c = clamp_size(dh_q, MAXH);
	assign dw_e = (dw_c > sw_e) ? sw_e : dw_c;
	assign dh_e = (dh_c > sh_e) ? sh_e : dh_c;

	always_comb begin
		case (mode_q)
			MODE_GRAY: nch = 3'd1;
			MODE_RGB:  nch = 3'd3;
			default:   nch = 3'd4;
		endcase
		if (nch > 3'(MAX_CHANNELS)) nch = 3'(MAX_CHANNELS);
		for (int i = 0; i < 4; i++) lane_en[i] = 3'(i) < nch;
	end

	// span ratio units, run after reset and after every register write
	bfd_state_t        state_q, state_d;
	logic              ratio_start;
	logic [SIZE_W-1:0] cq, cr, rq, rr;
	logic              cdone, rdone;

	assign ratio_start = (state_q == ST_START);

	bfd_ratio u_col_ratio (
		.clk(clk), .arst_n(arst_n), .start(ratio_start),
		.num(sw_e), .den(dw_e), .quo(cq), .rem(cr), .done(cdone)
	);

	bfd_ratio u_row_ratio (
		.clk(clk), .arst_n(arst_n), .start(ratio_start),
		.num(sh_e), .den(dh_e), .quo(rq), .rem(rr), .done(rdone)
	);

	// raster and span counters
	logic [SIZE_W-1:0] src_col_q, src_row_q, out_col_q, out_row_q;
	logic [SIZE_W-1:0] col_bound_q, row_bound_q, col_start_q, row_start_q;
	logic [SIZE_W-1:0] col_rem_q, row_rem_q;
	logic              accept, close, first_row, last_row, eor, eof, restart;
	logic [SIZE_W:0]   col_rem_sum, row_rem_sum;
	logic [SIZE_W-1:0] col_bound_nx, row_bound_nx, col_rem_nx, row_rem_nx;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign close     = ({1'b0, src_col_q} + 14'd1) >= {1'b0, col_bound_q};
	assign first_row = (src_row_q == row_start_q);
	assign last_row  = ({1'b0, src_row_q} + 14'd1) >= {1'b0, row_bound_q};
	assign eor       = ({1'b0, out_col_q} + 14'd1) >= {1'b0, dw_e};
	assign eof       = eor && (({1'b0, out_row_q} + 14'd1) >= {1'b0, dh_e});
	assign restart   = (state_q == ST_INIT) && cdone && rdone;

	// next span end: bound += s/d, remainder carry adds one more
	always_comb begin
		col_rem_sum  = {1'b0, col_rem_q} + {1'b0, cr};
		col_bound_nx = col_bound_q + cq;
		col_rem_nx   = col_rem_sum[SIZE_W-1:0];
		if (col_rem_sum >= {1'b0, dw_e}) begin
			col_rem_nx   = SIZE_W'(col_rem_sum - {1'b0, dw_e});
			col_bound_nx = col_bound_q + cq + SIZE_W'(1);
		end
		row_rem_sum  = {1'b0, row_rem_q} + {1'b0, rr};
		row_bound_nx = row_bound_q + rq;
		row_rem_nx   = row_rem_sum[SIZE_W-1:0];
		if (row_rem_sum >= {1'b0, dh_e}) begin
			row_rem_nx   = SIZE_W'(row_rem_sum - {1'b0, dh_e});
			row_bound_nx = row_bound_q + rq + SIZE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q   <= '0;
			src_row_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			col_start_q <= '0;
			row_start_q <= '0;
			col_bound_q <= '0;
			row_bound_q <= '0;
			col_rem_q   <= '0;
			row_rem_q   <= '0;
		end else if (restart) begin
			// frame restart once the ratios are known
			src_col_q   <= '0;
			src_row_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			col_start_q <= '0;
			row_start_q <= '0;
			col_bound_q <= cq;
			row_bound_q <= rq;
			col_rem_q   <= cr;
			row_rem_q   <= rr;
		end else if (accept) begin
			if (!close) begin
				src_col_q <= src_col_q + SIZE_W'(1);
			end else if (eor) begin
				// row of column spans done
				src_col_q   <= '0;
				out_col_q   <= '0;
				col_start_q <= '0;
				col_bound_q <= cq;
				col_rem_q   <= cr;
				if (last_row && eof) begin
					src_row_q   <= '0;
					out_row_q   <= '0;
					row_start_q <= '0;
					row_bound_q <= rq;
					row_rem_q   <= rr;
				end else if (last_row) begin
					out_row_q   <= out_row_q + SIZE_W'(1);
					row_start_q <= row_bound_q;
					row_bound_q <= row_bound_nx;
					row_rem_q   <= row_rem_nx;
					src_row_q   <= src_row_q + SIZE_W'(1);
				end else begin
					src_row_q <= src_row_q + SIZE_W'(1);
				end
			end else begin
				out_col_q   <= out_col_q + SIZE_W'(1);
				col_start_q <= col_bound_q;
				col_bound_q <= col_bound_nx;
				col_rem_q   <= col_rem_nx;
				src_col_q   <= src_col_q + SIZE_W'(1);
			end
		end
	end

	// request details captured when a column span closes
	logic              first_s1, last_s1, eor_s1, eof_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DIV_W-1:0]  div_s1, div_q;
	logic [2:0]        bit_q;

	always_ff @(posedge clk) begin
		if (accept && close) begin
			first_s1 <= first_row;
			last_s1  <= last_row;
			eor_s1   <= eor;
			eof_s1   <= eof;
			addr_s1  <= out_col_q[ADDR_W-1:0];
			div_s1   <= (col_bound_q - col_start_q) * (row_bound_q - row_start_q);
		end
		if (state_q == ST_SUM) div_q <= (div_s1 == '0) ? DIV_W'(1) : div_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (state_q == ST_SUM) begin
			bit_q <= 3'd7;
		end else if (state_q == ST_DIV) begin
			bit_q <= bit_q - 3'd1;
		end
	end

	// control sequencer
	logic merge_ready, merge_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_START;
		else state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		merge_load = 1'b0;
		case (state_q)
			ST_START: state_d = ST_INIT;
			ST_INIT:  if (cdone && rdone) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept && close) state_d = ST_SUM;
			end
			ST_SUM:   state_d = last_s1 ? ST_DIV : ST_IDLE;
			ST_DIV:   if (bit_q == '0) state_d = ST_OUT;
			ST_OUT: begin
				if (merge_ready) begin
					merge_load = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default:  state_d = ST_START;
		endcase
		// any register write restarts the ratios, even while they run
		if (cfg_wr && reg_idx <= REG_MODE) begin
			state_d    = ST_START;
			merge_load = 1'b0;
		end
	end

	// channel lanes
	lane_ctl_t   ctl;
	logic [31:0] lane_bus;

	always_comb begin
		ctl.acc       = accept;
		ctl.clr       = cfg_wr && (reg_idx <= REG_MODE);
		ctl.sum       = (state_q == ST_SUM);
		ctl.first_row = first_s1;
		ctl.step      = (state_q == ST_DIV);
		ctl.bit_idx   = bit_q;
		ctl.div       = div_q;
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		if (g < MAX_CHANNELS) begin : g_on
			bfd_lane #(.DEPTH(MAX_WIDTH), .ADDR_W(ADDR_W)) u_lane (
				.clk(clk), .arst_n(arst_n), .en(lane_en[g]), .ctl(ctl),
				.rd_addr(out_col_q[ADDR_W-1:0]), .wr_addr(addr_s1),
				.pix(s_tdata[g*8 +: 8]), .quo(lane_bus[g*8 +: 8])
			);
		end else begin : g_off
			assign lane_bus[g*8 +: 8] = 8'd0;
		end
	end

	bfd_merge u_merge (
		.clk(clk), .arst_n(arst_n), .load(merge_load), .lane_bus(lane_bus),
		.lane_en(lane_en), .eor(eor_s1), .eof(eof_s1), .can_load(merge_ready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	// span bounds stay ahead of their starts and the raster position
	`BFD_ASSERT_NOW(a_col_span, clk, arst_n, state_q == ST_IDLE, col_bound_q > col_start_q)
	`BFD_ASSERT_NOW(a_row_span, clk, arst_n, state_q == ST_IDLE, row_bound_q > row_start_q)
	`BFD_ASSERT_NOW(a_src_col, clk, arst_n, state_q == ST_IDLE, src_col_q < col_bound_q)
	// only the last row of a row span produces a request
	`BFD_ASSERT_NOW(a_out_last, clk, arst_n, state_q == ST_OUT, last_s1)
	`BFD_ASSERT_NEXT(a_close_sum, clk, arst_n, accept && close, state_q == ST_SUM)
endmodule

FILE: hdl/bfd_ratio.sv
// iterative quotient and remainder of two size values, one bit a cycle
module bfd_ratio
	import bfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SIZE_W-1:0] num,
	input  logic [SIZE_W-1:0] den,
	output logic [SIZE_W-1:0] quo,
	output logic [SIZE_W-1:0] rem,
	output logic              done
);
	logic [SIZE_W-1:0] quo_q, rem_q;
	logic [3:0]        cnt_q;
	logic              busy_q, done_q;
	logic [SIZE_W:0]   shifted;
	logic              fits;

	assign shifted = {rem_q, num[cnt_q]};
	assign fits    = shifted >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 4'(SIZE_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q        <= SIZE_W'(shifted - {1'b0, den});
				quo_q[cnt_q] <= 1'b1;
			end else begin
				rem_q <= shifted[SIZE_W-1:0];
			end
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

FILE: hdl/bfd_lane.sv
// one channel lane: span sum, line store and restoring divider
module bfd_lane
	import bfd_pkg::*;
#(
	parameter int DEPTH  = DEF_MAX_WIDTH,
	parameter int ADDR_W = $clog2(DEF_MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  lane_ctl_t         ctl,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        pix,
	output logic [7:0]        quo
);
	logic [SUM_W-1:0]  mem [DEPTH];
	logic [SUM_W-1:0]  rd_s1;
	logic [SPAN_W-1:0] span_q;
	logic [SUM_W-1:0]  rem_q;
	logic [7:0]        quo_q;
	logic [SUM_W-1:0]  sum_w;
	logic [SUM_W+1:0]  trial_div;
	logic              fits;

	assign sum_w     = (ctl.first_row ? '0 : rd_s1) + {{(SUM_W-SPAN_W){1'b0}}, span_q};
	assign trial_div = {{(SUM_W+2-DIV_W){1'b0}}, ctl.div} << ctl.bit_idx;
	assign fits      = {2'b00, rem_q} >= trial_div;

	always_ff @(posedge clk) begin
		if (ctl.acc) rd_s1 <= mem[rd_addr];
		if (ctl.sum && en) mem[wr_addr] <= sum_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= '0;
		end else if (ctl.clr) begin
			span_q <= '0;
		end else if (ctl.acc && en) begin
			span_q <= span_q + {{(SPAN_W-8){1'b0}}, pix};
		end else if (ctl.sum && en) begin
			span_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum) begin
			rem_q <= sum_w;
			quo_q <= '0;
		end else if (ctl.step && fits) begin
			rem_q              <= SUM_W'({2'b00, rem_q} - trial_div);
			quo_q[ctl.bit_idx] <= 1'b1;
		end
	end

	assign quo = quo_q;
endmodule

FILE: hdl/bfd_merge.sv
// merges lane results into the registered output stream
module bfd_merge
	import bfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [31:0] lane_bus,
	input  logic [3:0]  lane_en,
	input  logic        eor,
	input  logic        eof,
	output logic        can_load,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tuser
);
	logic        valid_q;
	logic [31:0] data_q;
	logic        last_q, user_q;
	logic [31:0] masked;

	always_comb begin
		for (int i = 0; i < 4; i++) masked[i*8 +: 8] = lane_en[i] ? lane_bus[i*8 +: 8] : 8'd0;
	end

	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (load) valid_q <= 1'b1;
		else if (m_tready) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= masked;
			last_q <= eor;
			user_q <= eof;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;
endmodule
